### rtl/sawss_pkg.sv
// package: codes, state type and control structs for the work slot scheduler
`timescale 1ns / 1ps
package sawss_pkg;

  localparam int SLOT_COUNT_DEF = 8;
  localparam int STREAM_COUNT   = 16;

  localparam logic [4:0] STREAM_ANY = 5'h1F;

  localparam logic [1:0] ACT_PUSH   = 2'd0;
  localparam logic [1:0] ACT_POP    = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_STOPPED = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_DRAIN,
    S_FETCH,
    S_REPLY
  } state_t;

  typedef struct packed {
    logic latch_req;
    logic push_exec;
    logic finish_exec;
    logic misc_exec;
    logic stop_exec;
    logic scan_clear;
    logic scan_issue;
    logic fetch;
    logic empty_exec;
    logic reply;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       run_en;
    logic       found;
    logic       scan_last;
  } stat_t;

endpackage

### rtl/sawss_ctrl.sv
// controller state machine sequencing push, pop scan, finish and replies
`timescale 1ns / 1ps
module sawss_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  sawss_pkg::stat_t stat,
  output sawss_pkg::cmd_t  cmd
);

  sawss_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sawss_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      sawss_pkg::S_IDLE: begin
        if (start) begin
          cmd.latch_req = 1'b1;
          state_nxt     = sawss_pkg::S_DISPATCH;
        end
      end
      sawss_pkg::S_DISPATCH: begin
        state_nxt = sawss_pkg::S_IDLE;
        case (stat.action)
          sawss_pkg::ACT_PUSH:   cmd.push_exec   = 1'b1;
          sawss_pkg::ACT_FINISH: cmd.finish_exec = 1'b1;
          sawss_pkg::ACT_POP: begin
            if (!stat.run_en) begin
              cmd.stop_exec = 1'b1;
            end else begin
              cmd.scan_clear = 1'b1;
              state_nxt      = sawss_pkg::S_SCAN;
            end
          end
          default: cmd.misc_exec = 1'b1;
        endcase
      end
      sawss_pkg::S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (stat.scan_last) begin
          state_nxt = sawss_pkg::S_DRAIN;
        end
      end
      sawss_pkg::S_DRAIN: begin
        state_nxt = sawss_pkg::S_FETCH;
      end
      sawss_pkg::S_FETCH: begin
        if (stat.found) begin
          cmd.fetch = 1'b1;
          state_nxt = sawss_pkg::S_REPLY;
        end else begin
          cmd.empty_exec = 1'b1;
          state_nxt      = sawss_pkg::S_IDLE;
        end
      end
      sawss_pkg::S_REPLY: begin
        cmd.reply = 1'b1;
        state_nxt = sawss_pkg::S_IDLE;
      end
      default: state_nxt = sawss_pkg::S_IDLE;
    endcase
  end

  assign busy = (state_r != sawss_pkg::S_IDLE);

endmodule

### rtl/sawss_dpath.sv
// datapath: slot table, order counter, oldest-first scan and result registers
`timescale 1ns / 1ps
module sawss_dpath #(
  parameter int SLOT_COUNT = sawss_pkg::SLOT_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sawss_pkg::cmd_t   cmd,
  output sawss_pkg::stat_t  stat,
  input  logic [1:0]        in_action,
  input  logic signed [4:0] in_stream,
  input  logic [31:0]       in_payload,
  input  logic [2:0]        in_slot,
  input  logic              cfg_valid,
  input  logic              cfg_data,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [2:0]        out_slot_out,
  output logic [31:0]       out_payload_out,
  output logic [63:0]       out_order_out
);

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOT_COUNT - 1);

  // request beat
  logic [1:0]  req_action_r;
  logic [4:0]  req_stream_r;
  logic [31:0] req_payload_r;
  logic [2:0]  req_slot_r;

  logic run_en_r;

  logic [SLOT_COUNT-1:0] slot_used_r, slot_used_nxt;
  logic [SLOT_COUNT-1:0] slot_active_r, slot_active_nxt;
  logic [63:0]           next_order_r;

  // slot table storage
  logic [4:0]  stream_mem  [SLOT_COUNT];
  logic [63:0] order_mem   [SLOT_COUNT];
  logic [31:0] payload_mem [SLOT_COUNT];

  logic [4:0]  stream_rd_r;
  logic [63:0] order_rd_r;
  logic [31:0] payload_rd_r;

  // scan state
  logic [SLOT_W-1:0] scan_idx_r;
  logic [SLOT_W-1:0] rd_idx_r;
  logic              rd_vld_r;
  logic              found_r;
  logic [SLOT_W-1:0] best_idx_r;
  logic [63:0]       best_order_r;

  logic              out_valid_r;
  logic [1:0]        status_r;
  logic [2:0]        slot_out_r;
  logic [31:0]       payload_out_r;
  logic [63:0]       order_out_r;

  logic [SLOT_W-1:0]     free_idx;
  logic                  has_free;
  logic [SLOT_COUNT-1:0] finish_mask;
  logic                  req_in_range;
  logic                  cand;
  logic                  emit;

  always_comb begin
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!slot_used_r[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign has_free = ~(&slot_used_r);

  always_comb begin
    finish_mask = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      finish_mask[i] = (32'(req_slot_r) == i);
    end
  end

  assign req_in_range = !req_stream_r[4] && (32'(req_stream_r[3:0]) < sawss_pkg::STREAM_COUNT);

  assign cand = rd_vld_r && slot_used_r[rd_idx_r] && !slot_active_r[rd_idx_r] &&
                ((stream_rd_r == sawss_pkg::STREAM_ANY) ||
                 (req_in_range && (stream_rd_r == req_stream_r))) &&
                (!found_r || (order_rd_r < best_order_r));

  assign emit = cmd.push_exec | cmd.finish_exec | cmd.misc_exec | cmd.stop_exec |
                cmd.empty_exec | cmd.reply;

  always_comb begin
    slot_used_nxt   = slot_used_r;
    slot_active_nxt = slot_active_r;
    if (cmd.push_exec && has_free) begin
      slot_used_nxt[free_idx]   = 1'b1;
      slot_active_nxt[free_idx] = 1'b0;
    end
    if (cmd.finish_exec) begin
      slot_used_nxt   = slot_used_r & ~finish_mask;
      slot_active_nxt = slot_active_r & ~finish_mask;
    end
    if (cmd.reply) begin
      slot_active_nxt[best_idx_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_en_r      <= 1'b1;
      slot_used_r   <= '0;
      slot_active_r <= '0;
      next_order_r  <= '0;
      rd_vld_r      <= 1'b0;
      found_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        run_en_r <= cfg_data;
      end
      slot_used_r   <= slot_used_nxt;
      slot_active_r <= slot_active_nxt;
      if (cmd.push_exec && has_free) begin
        next_order_r <= next_order_r + 64'd1;
      end
      rd_vld_r <= cmd.scan_issue;
      if (cmd.scan_clear) begin
        found_r <= 1'b0;
      end else if (cand) begin
        found_r <= 1'b1;
      end
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_action_r  <= in_action;
      req_stream_r  <= in_stream;
      req_payload_r <= in_payload;
      req_slot_r    <= in_slot;
    end
    if (cmd.scan_clear) begin
      scan_idx_r <= '0;
    end else if (cmd.scan_issue) begin
      scan_idx_r <= scan_idx_r + SLOT_W'(1);
    end
    rd_idx_r <= scan_idx_r;
    if (cand) begin
      best_idx_r   <= rd_idx_r;
      best_order_r <= order_rd_r;
    end
  end

  // table memories
  always_ff @(posedge clk) begin
    if (cmd.push_exec && has_free) begin
      stream_mem[free_idx]  <= req_stream_r;
      order_mem[free_idx]   <= next_order_r;
      payload_mem[free_idx] <= req_payload_r;
    end
    stream_rd_r <= stream_mem[scan_idx_r];
    order_rd_r  <= order_mem[scan_idx_r];
    if (cmd.fetch) begin
      payload_rd_r <= payload_mem[best_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status_r      <= sawss_pkg::ST_OK;
      slot_out_r    <= '0;
      payload_out_r <= '0;
      order_out_r   <= '0;
      if (cmd.push_exec) begin
        if (has_free) begin
          slot_out_r  <= 3'(free_idx);
          order_out_r <= next_order_r;
        end else begin
          status_r <= sawss_pkg::ST_FULL;
        end
      end
      if (cmd.finish_exec) begin
        slot_out_r <= req_slot_r;
      end
      if (cmd.stop_exec) begin
        status_r <= sawss_pkg::ST_STOPPED;
      end
      if (cmd.empty_exec) begin
        status_r <= sawss_pkg::ST_EMPTY;
      end
      if (cmd.reply) begin
        slot_out_r    <= 3'(best_idx_r);
        payload_out_r <= payload_rd_r;
        order_out_r   <= best_order_r;
      end
    end
  end

  assign stat.action    = req_action_r;
  assign stat.run_en    = run_en_r;
  assign stat.found     = found_r;
  assign stat.scan_last = (scan_idx_r == LAST_IDX);

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_slot_out    = slot_out_r;
  assign out_payload_out = payload_out_r;
  assign out_order_out   = order_out_r;

`ifndef SYNTHESIS
  a_active_in_used: assert property (@(posedge clk) disable iff (!rst_n)
    (slot_active_r & ~slot_used_r) == '0)
    else $error("active slot that is not used");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for two cycles");

  a_order_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_exec && has_free) |=> next_order_r == 64'($past(next_order_r) + 64'd1))
    else $error("sequence counter did not advance on push");

  a_reply_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.reply |-> found_r)
    else $error("pop reply without a selected slot");
`endif

endmodule

### rtl/stream_affine_work_slot_scheduler.sv
// top level: stream-affine oldest-first work slot scheduler
`timescale 1ns / 1ps
// A request beat is taken when start is high and busy is low; every request gives one
// result beat, shown for exactly one cycle with out_valid, which the receiver must take
// as it comes. Push, finish and other actions hold busy high only in the dispatch state,
// which registers the result. A pop scans the slot table one slot per cycle through the
// order and stream memories, in the dispatch, scan, drain, fetch and reply states when a
// slot is found (no reply state when nothing is pending, dispatch alone when stopped); the
// result is strobed once busy has fallen. A new request may be accepted in the same cycle
// a result is strobed. run_enable (cfg_valid / cfg_data, always ready) resets to 1; the user
// must write it only while no request is in flight, which the block does not enforce.
module stream_affine_work_slot_scheduler #(
  parameter int SLOT_COUNT = sawss_pkg::SLOT_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_action,
  input  logic signed [4:0] in_stream,
  input  logic [31:0]       in_payload,
  input  logic [2:0]        in_slot,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [2:0]        out_slot_out,
  output logic [31:0]       out_payload_out,
  output logic [63:0]       out_order_out,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);

  sawss_pkg::cmd_t  cmd;
  sawss_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  sawss_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  sawss_dpath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_action       (in_action),
    .in_stream       (in_stream),
    .in_payload      (in_payload),
    .in_slot         (in_slot),
    .cfg_valid       (cfg_valid),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_slot_out    (out_slot_out),
    .out_payload_out (out_payload_out),
    .out_order_out   (out_order_out)
  );

endmodule

### tb/slot_board_pkg.sv
// scoreboard for the work slot scheduler: slot table prediction and result checking
`timescale 1ns / 1ps
package slot_board_pkg;
  import sawss_pkg::*;

  localparam int SLOTS = SLOT_COUNT_DEF;
  localparam logic [1:0] ACT_NOP = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  slot;
    logic [31:0] payload;
    logic [63:0] order;
  } reply_t;

  class slot_board;
    bit          taken[SLOTS];
    bit          running[SLOTS];
    logic [4:0]  target[SLOTS];
    logic [63:0] seq[SLOTS];
    logic [31:0] desc[SLOTS];
    logic [63:0] seq_next;
    bit          run_on;
    reply_t      replies_due[$];
    int          errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        taken[i] = 1'b0;
        running[i] = 1'b0;
      end
      seq_next = '0;
      run_on = 1'b1;
      errors = 0;
    endfunction

    function void set_run(bit v);
      run_on = v;
    endfunction

    function int waiting();
      return replies_due.size();
    endfunction

    function int used_count();
      int n;
      n = 0;
      for (int i = 0; i < SLOTS; i++) n += taken[i];
      return n;
    endfunction

    function void take_request(logic [1:0] act, logic [4:0] stream, logic [31:0] pay,
                               logic [2:0] sl);
      reply_t r;
      int     sel;
      bit     hit;
      bit     req_ok;
      r = '0;
      sel = -1;
      case (act)
        ACT_PUSH: begin
          r.status = ST_FULL;
          for (int i = 0; i < SLOTS; i++) begin
            if (sel < 0 && !taken[i]) sel = i;
          end
          if (sel >= 0) begin
            taken[sel] = 1'b1;
            running[sel] = 1'b0;
            target[sel] = stream;
            desc[sel] = pay;
            seq[sel] = seq_next;
            seq_next = seq_next + 64'd1;
            r.status = ST_OK;
            r.slot = sel[2:0];
            r.order = seq[sel];
          end
        end
        ACT_POP: begin
          if (!run_on) begin
            r.status = ST_STOPPED;
          end else begin
            req_ok = $signed(stream) >= 0 && $signed(stream) < STREAM_COUNT;
            for (int i = 0; i < SLOTS; i++) begin
              if (taken[i] && !running[i]) begin
                hit = target[i] == STREAM_ANY || (req_ok && target[i] == stream);
                if (hit && (sel < 0 || seq[i] < seq[sel])) sel = i;
              end
            end
            if (sel < 0) begin
              r.status = ST_EMPTY;
            end else begin
              running[sel] = 1'b1;
              r.status = ST_OK;
              r.slot = sel[2:0];
              r.payload = desc[sel];
              r.order = seq[sel];
            end
          end
        end
        ACT_FINISH: begin
          if (sl < SLOTS) begin
            taken[sl] = 1'b0;
            running[sl] = 1'b0;
          end
          r.status = ST_OK;
          r.slot = sl;
        end
        default: r = '0;
      endcase
      replies_due.push_back(r);
    endfunction

    task flag(string msg);
      if (errors < 50) $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    task match_reply(reply_t got);
      reply_t want;
      if (replies_due.size() == 0) begin
        flag($sformatf("unexpected result beat status %0d slot %0d", got.status, got.slot));
        return;
      end
      want = replies_due.pop_front();
      if (got.status !== want.status)
        flag($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.slot !== want.slot)
        flag($sformatf("slot_out got %0d want %0d", got.slot, want.slot));
      if (got.payload !== want.payload)
        flag($sformatf("payload_out got %h want %h", got.payload, want.payload));
      if (got.order !== want.order)
        flag($sformatf("order_out got %h want %h", got.order, want.order));
    endtask
  endclass

endpackage

### tb/tb_top.sv
// testbench top: drives requests and run_enable writes, checks every result beat
`timescale 1ns / 1ps
module tb_top;
  import sawss_pkg::*;
  import slot_board_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_action;
  logic signed [4:0] in_stream;
  logic [31:0]       in_payload;
  logic [2:0]        in_slot;
  logic              out_valid;
  logic [1:0]        out_status;
  logic [2:0]        out_slot_out;
  logic [31:0]       out_payload_out;
  logic [63:0]       out_order_out;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_data;

  slot_board board;
  int        cycle_count;

  stream_affine_work_slot_scheduler DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_stream       (in_stream),
    .in_payload      (in_payload),
    .in_slot         (in_slot),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_slot_out    (out_slot_out),
    .out_payload_out (out_payload_out),
    .out_order_out   (out_order_out),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[stream_affine_work_slot_scheduler] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    reply_t got;
    if (rst_n) begin
      if (out_valid) begin
        got = {out_status, out_slot_out, out_payload_out, out_order_out};
        board.match_reply(got);
      end
      if (start && !busy) board.take_request(in_action, in_stream, in_payload, in_slot);
      if (cfg_valid && cfg_ready) board.set_run(cfg_data);
    end
  end

  task automatic send(input logic [1:0] act, input logic [4:0] s, input logic [31:0] pay,
                      input logic [2:0] sl);
    start      <= 1'b1;
    in_action  <= act;
    in_stream  <= s;
    in_payload <= pay;
    in_slot    <= sl;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 50) n = 0;
    else if (r < 90) n = $urandom_range(1, 4);
    else n = $urandom_range(8, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // lets the monitor note the last accepted beat before waiting for the board's queue to empty
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (board.waiting() != 0) @(posedge clk);
  endtask

  task automatic write_run(input logic v);
    drain();
    repeat ($urandom_range(0, 3)) @(posedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item();
    int         r;
    int         base;
    logic [1:0] act;
    logic [4:0] s;
    logic [2:0] sl;
    r = $urandom_range(0, 99);
    if (board.used_count() == SLOTS && r < 60) act = ACT_FINISH;
    else if (r < 35) act = ACT_PUSH;
    else if (r < 65) act = ACT_POP;
    else if (r < 95) act = ACT_FINISH;
    else act = ACT_NOP;
    r = $urandom_range(0, 99);
    if (act == ACT_PUSH) begin
      if (r < 30) s = STREAM_ANY;
      else if (r < 85) s = 5'($urandom_range(0, 3));
      else s = 5'($urandom_range(0, 31));
    end else begin
      if (r < 65) s = 5'($urandom_range(0, 3));
      else if (r < 80) s = 5'($urandom_range(0, STREAM_COUNT - 1));
      else s = 5'($urandom_range(0, 31));
    end
    sl = 3'($urandom_range(0, 7));
    if (act == ACT_FINISH && $urandom_range(0, 99) < 80) begin
      base = $urandom_range(0, SLOTS - 1);
      for (int i = 0; i < SLOTS; i++) begin
        if (board.taken[(base + i) % SLOTS]) sl = 3'((base + i) % SLOTS);
      end
    end
    send(act, s, $urandom, sl);
  endtask

  task automatic random_phase(input int count, input int pause_at);
    for (int k = 0; k < count; k++) begin
      if (k == pause_at) drain();
      random_item();
      if ((k % 128) < 96) idle();
    end
  endtask

  initial begin
    board       = new();
    cycle_count = 0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_action   = ACT_PUSH;
    in_stream   = '0;
    in_payload  = '0;
    in_slot     = '0;
    cfg_valid   = 1'b0;
    cfg_data    = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty pop, any-stream priority, bad streams, full table, frees, no-op, stopped pop
    send(ACT_POP, 5'd0, 32'h0, 3'd0);
    send(ACT_PUSH, STREAM_ANY, 32'hFFFF_FFFF, 3'd7);
    send(ACT_PUSH, 5'd15, 32'h0, 3'd0);
    idle();
    send(ACT_PUSH, 5'd0, 32'h1234_5678, 3'd0);
    send(ACT_PUSH, 5'h10, 32'hA5A5_A5A5, 3'd0);
    send(ACT_PUSH, 5'h1E, 32'h5A5A_5A5A, 3'd0);
    send(ACT_POP, 5'd15, 32'h0, 3'd0);
    idle();
    send(ACT_POP, 5'd15, 32'h0, 3'd0);
    send(ACT_POP, 5'd15, 32'h0, 3'd0);
    send(ACT_POP, 5'h1E, 32'h0, 3'd0);
    send(ACT_PUSH, STREAM_ANY, 32'hC0DE_0001, 3'd0);
    send(ACT_POP, STREAM_ANY, 32'h0, 3'd0);
    send(ACT_POP, 5'd0, 32'h0, 3'd0);
    send(ACT_PUSH, 5'd7, 32'h0000_0001, 3'd0);
    send(ACT_PUSH, 5'd8, 32'h8000_0000, 3'd0);
    send(ACT_PUSH, 5'd1, 32'h0F0F_0F0F, 3'd0);
    send(ACT_FINISH, 5'd0, 32'h0, 3'd3);
    send(ACT_FINISH, 5'd0, 32'h0, 3'd3);
    send(ACT_FINISH, 5'h1F, 32'hFFFF_FFFF, 3'd7);
    send(ACT_NOP, 5'h15, 32'hDEAD_BEEF, 3'd5);
    send(ACT_PUSH, 5'd0, 32'h7777_7777, 3'd6);
    send(ACT_POP, 5'd1, 32'h0, 3'd0);
    write_run(1'b0);
    send(ACT_POP, 5'd0, 32'h0, 3'd0);
    send(ACT_PUSH, STREAM_ANY, 32'h3333_3333, 3'd0);
    write_run(1'b1);
    send(ACT_POP, 5'd0, 32'h0, 3'd0);

    // random traffic in three phases with run_enable on, off and on, one full pause by the sender
    write_run(1'b1);
    random_phase(400, 200);
    write_run(1'b0);
    random_phase(120, -1);
    write_run(1'b1);
    random_phase(430, -1);

    drain();
    repeat (20) @(posedge clk);
    if (board.errors == 0) $display("[stream_affine_work_slot_scheduler] OK");
    else $display("[stream_affine_work_slot_scheduler] ERROR");
    $finish;
  end

endmodule
